// ===== rtl/core/gsa_pkg.sv =====
// gsa_pkg: shared types, codes and default sizes for the generational slot allocator
// no dependencies
`timescale 1ns / 1ps

package gsa_pkg;

   // default pool sizing
   localparam int SLOTS_DEF    = 256;
   localparam int GEN_BITS_DEF = 16;

   // fixed field widths
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;
   localparam int SERIAL_W = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CREATE      = 3'd0,
      ACT_DESTROY     = 3'd1,
      ACT_CHECK       = 3'd2,
      ACT_LOOKUP      = 3'd3,
      ACT_MARK_DIRTY  = 3'd4,
      ACT_MARK_GRAPH  = 3'd5,
      ACT_CLEAR       = 3'd6
   } action_type;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   // state update requests from the decision logic
   typedef struct packed {
      logic gen_we;     // write alive bit and generation of one slot
      logic pop;        // take the top of the free stack
      logic push;       // push a freed slot onto the free stack
      logic alloc_new;  // take the next never-used slot
      logic clear;      // empty the pool
      logic bump;       // advance the change serial
      logic set_dirty;
      logic set_graph;
   } gsa_ctl_type;

endpackage

// ===== rtl/core/generational_slot_allocator.sv =====
// generational_slot_allocator: top level of the handle allocator
// depends on gsa_pkg, gsa_ram and gsa_exec
`timescale 1ns / 1ps

// Handle allocator over a pool of SLOTS slots, each with an alive bit and a
// GEN_BITS-wide generation. Every request word gives exactly one response
// word, in order. A word accepted at one clock edge is held in the request
// register while the slot ram and the free stack ram deliver their entries;
// when the word leaves that register, the decision is made, the rams and
// counters are written and the response register is loaded. The request
// register refills at the same edge as it empties, so with rsp_ready high
// one word is taken every cycle; only a stalled response register holds
// the pipe. Writes made at the edge where the next word reads the rams are
// forwarded from a small bypass register, and the free stack read address
// is taken from the next value of the stack pointer. The free stack keeps
// each freed slot with its bumped generation, so a create needs a single
// ram read. Both rams come out of reset with undefined contents; no
// clearing pass is needed since only entries below the use count or the
// stack pointer are ever trusted.

module generational_slot_allocator #(
   parameter int SLOTS    = gsa_pkg::SLOTS_DEF,
   parameter int GEN_BITS = gsa_pkg::GEN_BITS_DEF,
   localparam int SlotW   = $clog2(SLOTS)
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [gsa_pkg::ACTION_W-1:0] req_action,
   input  logic [SlotW-1:0]             req_handle_slot,
   input  logic [GEN_BITS-1:0]          req_handle_generation,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [gsa_pkg::STATUS_W-1:0] rsp_status,
   output logic [SlotW-1:0]             rsp_result_slot,
   output logic [GEN_BITS-1:0]          rsp_result_generation,
   output logic                         rsp_is_alive,
   output logic [gsa_pkg::SERIAL_W-1:0] rsp_serial_out,
   output logic                         rsp_any_dirty_out,
   output logic                         rsp_any_graph_dirty_out
);

   import gsa_pkg::*;

   localparam int CntW   = SlotW + 1;
   localparam int SlotDW = GEN_BITS + 1;        // alive bit and generation
   localparam int StackW = SlotW + GEN_BITS;    // slot and its generation

   // request register
   logic                s1_valid_ff, s1_valid_in;
   logic [ACTION_W-1:0] s1_action_ff;
   logic [SlotW-1:0]    s1_slot_ff;
   logic [GEN_BITS-1:0] s1_gen_ff;

   // pool state
   logic [CntW-1:0]     count_ff, count_in;
   logic [CntW-1:0]     top_ff, top_in;
   logic [SERIAL_W-1:0] serial_ff, serial_in;
   logic                dirty_ff, dirty_in;
   logic                graph_ff, graph_in;

   // bypass of the writes made at the edge where the current word read the rams
   logic                gbyp_valid_ff;
   logic [SlotW-1:0]    gbyp_addr_ff;
   logic [SlotDW-1:0]   gbyp_data_ff;
   logic                sbyp_valid_ff;
   logic [SlotW-1:0]    sbyp_addr_ff;
   logic [StackW-1:0]   sbyp_data_ff;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SlotW-1:0]    rsp_slot_ff;
   logic [GEN_BITS-1:0] rsp_gen_ff;
   logic                rsp_alive_ff;
   logic [SERIAL_W-1:0] rsp_serial_ff;
   logic                rsp_dirty_ff;
   logic                rsp_graph_ff;

   logic                accept;
   logic                commit;

   logic [SlotDW-1:0]   slot_rd;
   logic [SlotDW-1:0]   slot_word;
   logic [StackW-1:0]   stack_rd;
   logic [StackW-1:0]   stack_word;
   logic [CntW-1:0]     top_dec_in;
   logic [CntW-1:0]     top_dec;
   logic [SlotW-1:0]    stack_rd_addr;

   gsa_ctl_type         ctl;
   logic [STATUS_W-1:0] x_status;
   logic [SlotW-1:0]    x_slot;
   logic [GEN_BITS-1:0] x_gen;
   logic                x_alive;
   logic [SlotW-1:0]    x_wr_addr;
   logic                x_wr_alive;
   logic [GEN_BITS-1:0] x_wr_gen;

   logic                gen_we;
   logic [SlotDW-1:0]   gen_wr_data;
   logic                stack_we;
   logic [SlotW-1:0]    stack_wr_addr;
   logic [StackW-1:0]   stack_wr_data;

   // handshakes: the request register empties whenever the response side can take a word
   assign commit    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || commit;
   assign accept    = req_valid && req_ready;

   // forwarded ram words for the word in the request register
   assign slot_word = (gbyp_valid_ff && (gbyp_addr_ff == s1_slot_ff)) ? gbyp_data_ff : slot_rd;
   assign top_dec   = top_ff - CntW'(1);
   assign stack_word = (sbyp_valid_ff && (sbyp_addr_ff == top_dec[SlotW-1:0]))
                       ? sbyp_data_ff : stack_rd;

   gsa_exec #(
      .SLOTS    (SLOTS),
      .GEN_BITS (GEN_BITS)
   ) u_exec (
      .action     (s1_action_ff),
      .hslot      (s1_slot_ff),
      .hgen       (s1_gen_ff),
      .mem_alive  (slot_word[SlotDW-1]),
      .mem_gen    (slot_word[GEN_BITS-1:0]),
      .stack_slot (stack_word[StackW-1:GEN_BITS]),
      .stack_gen  (stack_word[GEN_BITS-1:0]),
      .count      (count_ff),
      .top        (top_ff),
      .ctl        (ctl),
      .status     (x_status),
      .rslot      (x_slot),
      .rgen       (x_gen),
      .alive      (x_alive),
      .wr_addr    (x_wr_addr),
      .wr_alive   (x_wr_alive),
      .wr_gen     (x_wr_gen)
   );

   // ram writes happen only when the word leaves the request register
   assign gen_we        = commit && ctl.gen_we;
   assign gen_wr_data   = {x_wr_alive, x_wr_gen};
   assign stack_we      = commit && ctl.push;
   assign stack_wr_addr = top_ff[SlotW-1:0];
   assign stack_wr_data = {s1_slot_ff, x_wr_gen};

   // next pool state
   always_comb begin
      count_in  = count_ff;
      top_in    = top_ff;
      serial_in = serial_ff;
      dirty_in  = dirty_ff;
      graph_in  = graph_ff;
      if (commit) begin
         if (ctl.clear) begin
            count_in = '0;
            top_in   = '0;
         end else begin
            if (ctl.alloc_new) begin
               count_in = count_ff + CntW'(1);
            end
            if (ctl.pop) begin
               top_in = top_dec;
            end else if (ctl.push) begin
               top_in = top_ff + CntW'(1);
            end
         end
         if (ctl.bump) begin
            serial_in = serial_ff + SERIAL_W'(1);
         end
         dirty_in = dirty_ff || ctl.set_dirty;
         graph_in = graph_ff || ctl.set_graph;
      end
   end

   // the stack is read one below the pointer as it will stand after this edge
   assign top_dec_in    = top_in - CntW'(1);
   assign stack_rd_addr = top_dec_in[SlotW-1:0];

   gsa_ram #(
      .WIDTH (SlotDW),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (gen_we),
      .wr_addr (x_wr_addr),
      .wr_data (gen_wr_data),
      .rd_en   (accept),
      .rd_addr (req_handle_slot),
      .rd_data (slot_rd)
   );

   gsa_ram #(
      .WIDTH (StackW),
      .DEPTH (SLOTS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_wr_addr),
      .wr_data (stack_wr_data),
      .rd_en   (accept),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd)
   );

   assign s1_valid_in  = accept || (s1_valid_ff && !commit);
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_ready);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
         top_ff        <= '0;
         serial_ff     <= '0;
         dirty_ff      <= 1'b1;
         graph_ff      <= 1'b1;
         gbyp_valid_ff <= 1'b0;
         sbyp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         serial_ff    <= serial_in;
         dirty_ff     <= dirty_in;
         graph_ff     <= graph_in;
         if (accept) begin
            gbyp_valid_ff <= gen_we;
            sbyp_valid_ff <= stack_we;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= req_action;
         s1_slot_ff   <= req_handle_slot;
         s1_gen_ff    <= req_handle_generation;
         gbyp_addr_ff <= x_wr_addr;
         gbyp_data_ff <= gen_wr_data;
         sbyp_addr_ff <= stack_wr_addr;
         sbyp_data_ff <= stack_wr_data;
      end
      if (commit) begin
         rsp_status_ff <= x_status;
         rsp_slot_ff   <= x_slot;
         rsp_gen_ff    <= x_gen;
         rsp_alive_ff  <= x_alive;
         rsp_serial_ff <= serial_in;
         rsp_dirty_ff  <= dirty_in;
         rsp_graph_ff  <= graph_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = rsp_status_ff;
   assign rsp_result_slot         = rsp_slot_ff;
   assign rsp_result_generation   = rsp_gen_ff;
   assign rsp_is_alive            = rsp_alive_ff;
   assign rsp_serial_out          = rsp_serial_ff;
   assign rsp_any_dirty_out       = rsp_dirty_ff;
   assign rsp_any_graph_dirty_out = rsp_graph_ff;

endmodule

// ===== rtl/core/gsa_ram.sv =====
// gsa_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module gsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/gsa_exec.sv =====
// gsa_exec: per-word decision logic of the slot allocator
// depends on gsa_pkg
`timescale 1ns / 1ps

module gsa_exec #(
   parameter int SLOTS    = gsa_pkg::SLOTS_DEF,
   parameter int GEN_BITS = gsa_pkg::GEN_BITS_DEF,
   localparam int SlotW   = $clog2(SLOTS),
   localparam int CntW    = SlotW + 1
) (
   input  logic [gsa_pkg::ACTION_W-1:0] action,
   input  logic [SlotW-1:0]             hslot,
   input  logic [GEN_BITS-1:0]          hgen,
   input  logic                         mem_alive,
   input  logic [GEN_BITS-1:0]          mem_gen,
   input  logic [SlotW-1:0]             stack_slot,
   input  logic [GEN_BITS-1:0]          stack_gen,
   input  logic [CntW-1:0]              count,
   input  logic [CntW-1:0]              top,
   output gsa_pkg::gsa_ctl_type         ctl,
   output logic [gsa_pkg::STATUS_W-1:0] status,
   output logic [SlotW-1:0]             rslot,
   output logic [GEN_BITS-1:0]          rgen,
   output logic                         alive,
   output logic [SlotW-1:0]             wr_addr,
   output logic                         wr_alive,
   output logic [GEN_BITS-1:0]          wr_gen
);

   import gsa_pkg::*;

   logic in_range;
   logic live;

   assign in_range = ({1'b0, hslot} < count);
   assign live     = in_range && mem_alive && (mem_gen == hgen);

   always_comb begin
      ctl      = '0;
      status   = ST_OK;
      rslot    = '0;
      rgen     = '0;
      alive    = 1'b0;
      wr_addr  = hslot;
      wr_alive = 1'b0;
      wr_gen   = mem_gen + {{(GEN_BITS-1){1'b0}}, 1'b1};
      case (action_type'(action))
         ACT_CREATE: begin
            if (top != '0) begin
               ctl.pop = 1'b1;
               rslot   = stack_slot;
               rgen    = stack_gen;
            end else if (count < CntW'(SLOTS)) begin
               ctl.alloc_new = 1'b1;
               rslot         = count[SlotW-1:0];
            end else begin
               status = ST_FULL;
            end
            if (status == ST_OK) begin
               ctl.gen_we    = 1'b1;
               ctl.bump      = 1'b1;
               ctl.set_dirty = 1'b1;
               ctl.set_graph = 1'b1;
               wr_addr       = rslot;
               wr_alive      = 1'b1;
               wr_gen        = rgen;
               alive         = 1'b1;
            end
         end
         ACT_DESTROY: begin
            if (live) begin
               ctl.gen_we    = 1'b1;
               ctl.push      = (top < CntW'(SLOTS));
               ctl.bump      = 1'b1;
               ctl.set_dirty = 1'b1;
               ctl.set_graph = 1'b1;
            end else begin
               status = ST_INVALID;
            end
         end
         ACT_CHECK: begin
            alive  = live;
            status = live ? ST_OK : ST_INVALID;
         end
         ACT_LOOKUP: begin
            if (in_range && mem_alive) begin
               rslot = hslot;
               rgen  = mem_gen;
               alive = 1'b1;
            end else begin
               status = ST_INVALID;
            end
         end
         ACT_MARK_DIRTY: begin
            if (live) begin
               ctl.set_dirty = 1'b1;
               ctl.bump      = 1'b1;
               alive         = 1'b1;
            end else begin
               status = ST_INVALID;
            end
         end
         ACT_MARK_GRAPH: begin
            if (live) begin
               ctl.set_graph = 1'b1;
               ctl.bump      = 1'b1;
               alive         = 1'b1;
            end else begin
               status = ST_INVALID;
            end
         end
         ACT_CLEAR: begin
            ctl.clear     = 1'b1;
            ctl.bump      = 1'b1;
            ctl.set_dirty = 1'b1;
            ctl.set_graph = 1'b1;
         end
         default: begin
            status = ST_INVALID;
         end
      endcase
   end

endmodule
